// File: hdl/mjwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mjwm_pkg;

    // stick request and mixer result
    typedef struct packed {
        logic [11:0] stick_x;
        logic [11:0] stick_y;
        logic [11:0] stick_rotate;
    } stick_t;

    typedef struct packed {
        logic [9:0] wheel_speed_0;
        logic [9:0] wheel_speed_1;
        logic [9:0] wheel_speed_2;
        logic [9:0] wheel_speed_3;
        logic [3:0] direction_mask;
        logic [3:0] sector;
        logic [1:0] turn_state;
    } mix_t;

    // configuration register indexes
    localparam logic [1:0] CFG_DEAD_BAND_LOW  = 2'd0;
    localparam logic [1:0] CFG_DEAD_BAND_HIGH = 2'd1;

    localparam logic [11:0] DEAD_BAND_LOW_RST  = 12'd1800;
    localparam logic [11:0] DEAD_BAND_HIGH_RST = 12'd2300;

    // sector codes
    localparam logic [3:0] SEC_DEAD   = 4'd0;
    localparam logic [3:0] SEC_FWD    = 4'd1;
    localparam logic [3:0] SEC_RIGHT  = 4'd2;
    localparam logic [3:0] SEC_BACK   = 4'd3;
    localparam logic [3:0] SEC_LEFT   = 4'd4;
    localparam logic [3:0] SEC_DIAG5  = 4'd5;
    localparam logic [3:0] SEC_DIAG6  = 4'd6;
    localparam logic [3:0] SEC_DIAG7  = 4'd7;
    localparam logic [3:0] SEC_DIAG8  = 4'd8;
    localparam logic [3:0] SEC_DIAG9  = 4'd9;
    localparam logic [3:0] SEC_DIAG10 = 4'd10;
    localparam logic [3:0] SEC_DIAG11 = 4'd11;
    localparam logic [3:0] SEC_DIAG12 = 4'd12;

    // turn codes
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_LEFT  = 2'd2;

    // direction masks
    localparam logic [3:0] MASK_RIGHT_SPIN = 4'hC;
    localparam logic [3:0] MASK_LEFT_SPIN  = 4'h3;
    localparam logic [3:0] MASK_FWD        = 4'h0;
    localparam logic [3:0] MASK_RIGHT      = 4'h6;
    localparam logic [3:0] MASK_BACK       = 4'hF;
    localparam logic [3:0] MASK_LEFT       = 4'h9;

    localparam logic [9:0] SPEED_FULL = 10'd1000;

    // floor(d*1000/1500) = floor(d*87382 / 2^17), exact for d < 2^16
    localparam logic [28:0] SPEED_RECIP = 29'd87382;
    // floor(p/1000) = floor(p*1073742 / 2^30), exact for p < 6e6
    localparam logic [40:0] TRIM_RECIP  = 41'd1073742;

    // distance past the dead band edge, scaled and clamped
    function automatic logic [9:0] axis_speed(input logic [11:0] v,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi);
        logic [11:0] d;
        logic [28:0] p;
        logic [11:0] q;
        if (v >= hi)
        begin
            d = v - hi;
        end
        else if (v <= lo)
        begin
            d = lo - v;
        end
        else
        begin
            d = '0;
        end
        p = {17'b0, d} * SPEED_RECIP;
        q = p[28:17];
        return (q > {2'b0, SPEED_FULL}) ? SPEED_FULL : q[9:0];
    endfunction

    // ordered tests, also used with crossed edges
    function automatic logic [3:0] classify(input logic [11:0] x,
                                             input logic [11:0] y,
                                             input logic [11:0] lo,
                                             input logic [11:0] hi);
        logic xin;
        logic yin;
        logic [3:0] s;
        xin = (x >= lo) && (x <= hi);
        yin = (y >= lo) && (y <= hi);
        if (xin && yin)
            s = SEC_DEAD;
        else if (xin && y >= hi)
            s = SEC_FWD;
        else if (xin && y <= lo)
            s = SEC_BACK;
        else if (x >= hi && yin)
            s = SEC_RIGHT;
        else if (x <= lo && yin)
            s = SEC_LEFT;
        else if (x >= hi && y >= hi)
            s = (x <= y) ? SEC_DIAG6 : SEC_DIAG7;
        else if (x <= lo && y <= lo)
            s = (x <= y) ? SEC_DIAG11 : SEC_DIAG10;
        else if (x <= lo && y >= hi)
            s = ((lo - x) <= (y - hi)) ? SEC_DIAG5 : SEC_DIAG12;
        else if (x >= hi && y <= lo)
            s = ((x - hi) >= (lo - y)) ? SEC_DIAG8 : SEC_DIAG9;
        else
            s = SEC_DEAD;
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mecanum_joystick_wheel_mixer_top.sv
// a request passes the input, stage 2, stage 3 and result registers to reach mix
// throughput: one request per unstalled cycle, set by the four-stage valid pipeline
// every stage advances on its own, so bubbles close up under a stalled output
// reset (rst_n low, asynchronous): pipeline empty, held direction mask zero,
// dead band edges back to 1800 and 2300
`timescale 1ns / 1ps
`default_nettype none

module mecanum_joystick_wheel_mixer_top
    import mjwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stick request channel
    input  wire logic        stick_valid,
    output logic             stick_stall,
    input  wire stick_t      stick,
    // mixer result channel
    output logic             mix_valid,
    input  wire logic        mix_stall,
    output mix_t             mix,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [11:0] dead_band_low_reg;
    logic [11:0] dead_band_high_reg;

    // issue writes only while the pipeline is empty; the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_low_reg  <= DEAD_BAND_LOW_RST;
            dead_band_high_reg <= DEAD_BAND_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEAD_BAND_LOW:  dead_band_low_reg  <= cfg_data;
                CFG_DEAD_BAND_HIGH: dead_band_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control
    // a stage loads when it is empty or its content moves on
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic load_out;
    logic load_s3;
    logic load_s2;
    logic load_s1;

    assign load_out    = !out_valid_reg || !mix_stall;
    assign load_s3     = !s3_valid_reg  || load_out;
    assign load_s2     = !s2_valid_reg  || load_s3;
    assign load_s1     = !s1_valid_reg  || load_s2;
    assign stick_stall = !load_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
                s1_valid_reg <= stick_valid;
            if (load_s2)
                s2_valid_reg <= s1_valid_reg;
            if (load_s3)
                s3_valid_reg <= s2_valid_reg;
            if (load_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: input register
    // ---------------------------------------------------------------
    stick_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (load_s1 && stick_valid)
            s1_reg <= stick;
    end

    // ---------------------------------------------------------------
    // stage 2: axis speeds, turn direction, sector
    // ---------------------------------------------------------------
    logic [9:0] sx_next;
    logic [9:0] sy_next;
    logic [9:0] sr_next;
    logic [1:0] turn_next;
    logic [3:0] sec_next;

    always_comb
    begin
        sx_next = axis_speed(s1_reg.stick_x, dead_band_low_reg, dead_band_high_reg);
        sy_next = axis_speed(s1_reg.stick_y, dead_band_low_reg, dead_band_high_reg);
        sr_next = axis_speed(s1_reg.stick_rotate, dead_band_low_reg, dead_band_high_reg);
        // an edge value counts as on the side of that edge
        if (s1_reg.stick_rotate >= dead_band_high_reg)
            turn_next = TURN_RIGHT;
        else if (s1_reg.stick_rotate <= dead_band_low_reg)
            turn_next = TURN_LEFT;
        else
            turn_next = TURN_NONE;
        sec_next = classify(s1_reg.stick_x, s1_reg.stick_y,
                            dead_band_low_reg, dead_band_high_reg);
    end

    logic [9:0] sx2_reg;
    logic [9:0] sy2_reg;
    logic [9:0] sr2_reg;
    logic [1:0] turn2_reg;
    logic [3:0] sec2_reg;

    always_ff @(posedge clk)
    begin
        if (load_s2 && s1_valid_reg)
        begin
            sx2_reg   <= sx_next;
            sy2_reg   <= sy_next;
            sr2_reg   <= sr_next;
            turn2_reg <= turn_next;
            sec2_reg  <= sec_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: base speed, sector difference, trim product
    // ---------------------------------------------------------------
    logic        ybase;
    logic [9:0]  base_next;
    logic [9:0]  dv_next;
    logic [9:0]  trim_factor;
    logic [19:0] prod_next;

    always_comb
    begin
        // sectors that take the y speed as the base
        ybase = (sec2_reg inside {SEC_FWD, SEC_BACK, SEC_DIAG5, SEC_DIAG6,
                                  SEC_DIAG9, SEC_DIAG10});
        base_next = ybase ? sy2_reg : sx2_reg;
        // difference clamps at zero
        if (ybase)
            dv_next = (sy2_reg > sx2_reg) ? (sy2_reg - sx2_reg) : '0;
        else
            dv_next = (sx2_reg > sy2_reg) ? (sx2_reg - sy2_reg) : '0;
        trim_factor = SPEED_FULL - sr2_reg;
        prod_next   = {10'b0, base_next} * {10'b0, trim_factor};
    end

    logic [9:0]  base3_reg;
    logic [9:0]  dv3_reg;
    logic [19:0] prod3_reg;
    logic [9:0]  sr3_reg;
    logic [1:0]  turn3_reg;
    logic [3:0]  sec3_reg;

    always_ff @(posedge clk)
    begin
        if (load_s3 && s2_valid_reg)
        begin
            base3_reg <= base_next;
            dv3_reg   <= dv_next;
            prod3_reg <= prod_next;
            sr3_reg   <= sr2_reg;
            turn3_reg <= turn2_reg;
            sec3_reg  <= sec2_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: trim divide by 1000, wheel mixing, direction mask
    // ---------------------------------------------------------------
    logic [3:0]  held_direction_reg;
    logic [40:0] trim_prod;
    logic [9:0]  trimmed;
    logic        flip;
    logic        outer;
    logic [9:0]  first;
    logic [9:0]  second;
    logic [3:0]  mask_next;
    mix_t        mix_next;

    always_comb
    begin
        trim_prod = {21'b0, prod3_reg} * TRIM_RECIP;
        trimmed   = trim_prod[39:30];

        flip  = (sec3_reg inside {SEC_DIAG8, SEC_DIAG9, SEC_DIAG10, SEC_DIAG11});
        outer = (sec3_reg inside {SEC_DIAG5, SEC_DIAG8, SEC_DIAG9, SEC_DIAG12});

        first  = base3_reg;
        second = base3_reg;
        if (turn3_reg == TURN_RIGHT)
        begin
            if (flip)
                first = trimmed;
            else
                second = trimmed;
        end
        else if (turn3_reg == TURN_LEFT)
        begin
            if (flip)
                second = trimmed;
            else
                first = trimmed;
        end

        // direction mask by sector; dead zone keeps the held mask unless a turn spins it
        case (sec3_reg)
            SEC_FWD, SEC_DIAG5, SEC_DIAG6:    mask_next = MASK_FWD;
            SEC_RIGHT, SEC_DIAG7, SEC_DIAG8:  mask_next = MASK_RIGHT;
            SEC_BACK, SEC_DIAG9, SEC_DIAG10:  mask_next = MASK_BACK;
            SEC_LEFT, SEC_DIAG11, SEC_DIAG12: mask_next = MASK_LEFT;
            default:                          mask_next = held_direction_reg;
        endcase

        mix_next.sector     = sec3_reg;
        mix_next.turn_state = turn3_reg;

        if (sec3_reg == SEC_DEAD)
        begin
            // spin in place at the rotation speed
            if (turn3_reg == TURN_RIGHT)
                mask_next = MASK_RIGHT_SPIN;
            else if (turn3_reg == TURN_LEFT)
                mask_next = MASK_LEFT_SPIN;
            mix_next.wheel_speed_0 = sr3_reg;
            mix_next.wheel_speed_1 = sr3_reg;
            mix_next.wheel_speed_2 = sr3_reg;
            mix_next.wheel_speed_3 = sr3_reg;
        end
        else if (sec3_reg inside {SEC_FWD, SEC_BACK})
        begin
            // straight y travel: trim one side pair
            mix_next.wheel_speed_0 = (turn3_reg == TURN_LEFT)  ? trimmed : base3_reg;
            mix_next.wheel_speed_1 = (turn3_reg == TURN_LEFT)  ? trimmed : base3_reg;
            mix_next.wheel_speed_2 = (turn3_reg == TURN_RIGHT) ? trimmed : base3_reg;
            mix_next.wheel_speed_3 = (turn3_reg == TURN_RIGHT) ? trimmed : base3_reg;
        end
        else if (sec3_reg inside {SEC_RIGHT, SEC_LEFT})
        begin
            // straight x travel: trim a diagonal pair
            mix_next.wheel_speed_0 = (turn3_reg == TURN_RIGHT) ? trimmed : base3_reg;
            mix_next.wheel_speed_1 = (turn3_reg == TURN_LEFT)  ? trimmed : base3_reg;
            mix_next.wheel_speed_2 = (turn3_reg == TURN_RIGHT) ? trimmed : base3_reg;
            mix_next.wheel_speed_3 = (turn3_reg == TURN_LEFT)  ? trimmed : base3_reg;
        end
        else if (outer)
        begin
            mix_next.wheel_speed_0 = dv3_reg;
            mix_next.wheel_speed_1 = first;
            mix_next.wheel_speed_2 = second;
            mix_next.wheel_speed_3 = dv3_reg;
        end
        else
        begin
            mix_next.wheel_speed_0 = first;
            mix_next.wheel_speed_1 = dv3_reg;
            mix_next.wheel_speed_2 = dv3_reg;
            mix_next.wheel_speed_3 = second;
        end

        mix_next.direction_mask = mask_next;
    end

    // ---------------------------------------------------------------
    // result register and held direction
    // held mask follows the order in which results leave stage 4
    // ---------------------------------------------------------------
    mix_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_direction_reg <= '0;
        end
        else if (load_out && s3_valid_reg)
        begin
            held_direction_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out && s3_valid_reg)
            out_reg <= mix_next;
    end

    assign mix_valid = out_valid_reg;
    assign mix       = out_reg;

endmodule

`default_nettype wire

// File: hdl/mjwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mjwm_checker
    import mjwm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        stick_valid,
    input wire logic        stick_stall,
    input wire stick_t      stick,
    input wire logic        mix_valid,
    input wire logic        mix_stall,
    input wire mix_t        mix,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [11:0] cfg_data
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix_stall |=> mix_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix_stall |=> $stable(mix))
        else $error("result changed while stalled");

    // dead zone with a right turn spins right in place
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix.sector == SEC_DEAD && mix.turn_state == TURN_RIGHT
        |-> mix.direction_mask == MASK_RIGHT_SPIN)
        else $error("right spin mask wrong");

    // dead zone without a turn stops every wheel
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix.sector == SEC_DEAD && mix.turn_state == TURN_NONE
        |-> mix.wheel_speed_0 == 10'd0 && mix.wheel_speed_1 == 10'd0 &&
            mix.wheel_speed_2 == 10'd0 && mix.wheel_speed_3 == 10'd0)
        else $error("wheels move in idle dead zone");

    // forward travel never reverses a wheel
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && (mix.sector == SEC_FWD || mix.sector == SEC_DIAG5 ||
                      mix.sector == SEC_DIAG6)
        |-> mix.direction_mask == MASK_FWD)
        else $error("forward mask wrong");

endmodule

bind mecanum_joystick_wheel_mixer_top mjwm_checker u_mjwm_checker (.*);

`default_nettype wire

// File: bench/mjwm_mix_checker.sv
`timescale 1ns / 1ps

module mjwm_mix_checker
    import mjwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        stick_valid,
    input  wire logic        stick_stall,
    input  wire stick_t      stick,
    input  wire logic        mix_valid,
    input  wire logic        mix_stall,
    input  wire mix_t        mix,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    int   band_lo = DEAD_BAND_LOW_RST;
    int   band_hi = DEAD_BAND_HIGH_RST;
    logic [3:0] held_mask = MASK_FWD;
    mix_t expected_mix [$];

    // scaled distance past the band edge
    function automatic int axis_rate(input int v);
        int d;
        if (v >= band_hi)
            d = v - band_hi;
        else if (v <= band_lo)
            d = band_lo - v;
        else
            return 0;
        d = d * 1000 / 1500;
        return (d > 1000) ? 1000 : d;
    endfunction

    function automatic logic [3:0] sector_of(input int x, input int y);
        logic xin;
        logic yin;
        xin = (x >= band_lo) && (x <= band_hi);
        yin = (y >= band_lo) && (y <= band_hi);
        if (xin && yin)                    return SEC_DEAD;
        if (xin && y >= band_hi)           return SEC_FWD;
        if (xin && y <= band_lo)           return SEC_BACK;
        if (x >= band_hi && yin)           return SEC_RIGHT;
        if (x <= band_lo && yin)           return SEC_LEFT;
        if (x >= band_hi && y >= band_hi)  return (x <= y) ? SEC_DIAG6 : SEC_DIAG7;
        if (x <= band_lo && y <= band_lo)  return (x <= y) ? SEC_DIAG11 : SEC_DIAG10;
        if (x <= band_lo && y >= band_hi)
            return ((band_lo - x) <= (y - band_hi)) ? SEC_DIAG5 : SEC_DIAG12;
        if (x >= band_hi && y <= band_lo)
            return ((x - band_hi) >= (band_lo - y)) ? SEC_DIAG8 : SEC_DIAG9;
        return SEC_DEAD;
    endfunction

    function automatic logic [3:0] heading_mask(input int k);
        case (k)
            0:       return MASK_FWD;
            1:       return MASK_RIGHT;
            2:       return MASK_BACK;
            default: return MASK_LEFT;
        endcase
    endfunction

    function automatic mix_t predict_mix(input stick_t s);
        int   x;
        int   y;
        int   r;
        int   sx;
        int   sy;
        int   sr;
        int   base;
        int   trimmed;
        int   dv;
        int   first;
        int   second;
        int   p;
        int   w [4];
        logic ybase;
        logic outer;
        logic flip;
        logic [1:0] turn;
        logic [3:0] sec;
        logic [3:0] msk;
        mix_t m;
        x = s.stick_x;
        y = s.stick_y;
        r = s.stick_rotate;
        sx = axis_rate(x);
        sy = axis_rate(y);
        sr = axis_rate(r);
        if (r >= band_hi)
            turn = TURN_RIGHT;
        else if (r <= band_lo)
            turn = TURN_LEFT;
        else
            turn = TURN_NONE;
        sec = sector_of(x, y);
        msk = held_mask;
        if (sec == SEC_DEAD)
        begin
            // spin in place, or keep the last mask when rotation is idle
            if (turn == TURN_RIGHT)
                msk = MASK_RIGHT_SPIN;
            else if (turn == TURN_LEFT)
                msk = MASK_LEFT_SPIN;
            w = '{sr, sr, sr, sr};
        end
        else if (sec <= SEC_LEFT)
        begin
            ybase = (sec == SEC_FWD) || (sec == SEC_BACK);
            base = ybase ? sy : sx;
            trimmed = base * (1000 - sr) / 1000;
            msk = heading_mask(sec - 1);
            w = '{base, base, base, base};
            if (ybase)
            begin
                if (turn == TURN_RIGHT)
                begin
                    w[2] = trimmed;
                    w[3] = trimmed;
                end
                else if (turn == TURN_LEFT)
                begin
                    w[0] = trimmed;
                    w[1] = trimmed;
                end
            end
            else
            begin
                if (turn == TURN_RIGHT)
                begin
                    w[0] = trimmed;
                    w[2] = trimmed;
                end
                else if (turn == TURN_LEFT)
                begin
                    w[1] = trimmed;
                    w[3] = trimmed;
                end
            end
        end
        else
        begin
            p = sec - 4;
            ybase = (p == 1) || (p == 2) || (p == 5) || (p == 6);
            outer = (p == 1) || (p == 4) || (p == 5) || (p == 8);
            flip = (p >= 4) && (p <= 7);
            base = ybase ? sy : sx;
            trimmed = base * (1000 - sr) / 1000;
            // difference floors at zero
            if (ybase)
                dv = (sy > sx) ? sy - sx : 0;
            else
                dv = (sx > sy) ? sx - sy : 0;
            first = base;
            second = base;
            msk = heading_mask((p - 1) >> 1);
            if (turn == TURN_RIGHT)
            begin
                if (flip)
                    first = trimmed;
                else
                    second = trimmed;
            end
            else if (turn == TURN_LEFT)
            begin
                if (flip)
                    second = trimmed;
                else
                    first = trimmed;
            end
            if (outer)
                w = '{dv, first, second, dv};
            else
                w = '{first, dv, dv, second};
        end
        m.wheel_speed_0 = 10'(w[0]);
        m.wheel_speed_1 = 10'(w[1]);
        m.wheel_speed_2 = 10'(w[2]);
        m.wheel_speed_3 = 10'(w[3]);
        m.direction_mask = msk;
        m.sector = sec;
        m.turn_state = turn;
        return m;
    endfunction

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t mix.%s mismatch: expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mix_t want;
        if (!rst_n)
        begin
            band_lo = DEAD_BAND_LOW_RST;
            band_hi = DEAD_BAND_HIGH_RST;
            held_mask = MASK_FWD;
            expected_mix.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (mix_valid && !mix_stall)
            begin
                if (expected_mix.size() == 0)
                begin
                    $display("%0t mix result with nothing expected: expected none actual %h",
                             $time, mix);
                    fail_count++;
                end
                else
                begin
                    want = expected_mix.pop_front();
                    check_field("wheel_speed_0", want.wheel_speed_0, mix.wheel_speed_0);
                    check_field("wheel_speed_1", want.wheel_speed_1, mix.wheel_speed_1);
                    check_field("wheel_speed_2", want.wheel_speed_2, mix.wheel_speed_2);
                    check_field("wheel_speed_3", want.wheel_speed_3, mix.wheel_speed_3);
                    check_field("direction_mask", want.direction_mask, mix.direction_mask);
                    check_field("sector", want.sector, mix.sector);
                    check_field("turn_state", want.turn_state, mix.turn_state);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DEAD_BAND_LOW)
                    band_lo = cfg_data;
                else if (cfg_index == CFG_DEAD_BAND_HIGH)
                    band_hi = cfg_data;
            end
            if (stick_valid && !stick_stall)
            begin
                want = predict_mix(stick);
                held_mask = want.direction_mask;
                expected_mix.push_back(want);
            end
            pending = expected_mix.size();
        end
    end

endmodule

// File: bench/tb_mecanum_joystick_wheel_mixer_top.sv
`timescale 1ns / 1ps

module tb_mecanum_joystick_wheel_mixer_top;
    import mjwm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        stick_valid;
    logic        stick_stall;
    stick_t      stick;
    logic        mix_valid;
    logic        mix_stall;
    mix_t        mix;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    int          fail_count;
    int          pending;

    // idling controls for the sender and the receiver
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    logic        hold_off_req = 1'b0;

    // directed stick requests at the reset dead band (1800..2300): x, y, rotation
    localparam int DIRECTED [25][3] = '{
        '{2050, 2050, 2050},   // dead zone, no rotation, held mask from reset
        '{2050, 2050, 4095},   // spin right at full speed
        '{2050, 2050, 2050},   // dead zone keeps the spin-right mask
        '{2050, 2050, 0},      // spin left, speed clamps
        '{1800, 2300, 1800},   // stick on both band edges, rotation on low edge
        '{2300, 1800, 2300},   // mirrored, rotation on high edge
        '{2050, 4095, 2050},   // forward axis
        '{4095, 2050, 4095},   // right axis with right turn
        '{2050, 0, 0},         // back axis with left turn
        '{0, 2050, 3000},      // left axis with partial right trim
        '{2050, 3800, 2050},   // distance exactly one span
        '{3801, 2050, 0},      // one past the span
        '{1500, 3500, 2800},   // diagonal sectors five through twelve
        '{3000, 3500, 1000},
        '{3500, 3000, 2050},
        '{3500, 1700, 2600},
        '{2400, 500, 1300},
        '{1000, 500, 4095},
        '{500, 1000, 0},
        '{500, 2400, 2500},
        '{3000, 3000, 3000},   // equal x and y in the upper quadrant
        '{0, 0, 0},
        '{4095, 4095, 4095},
        '{4095, 0, 2050},
        '{0, 4095, 2050}
    };

    mecanum_joystick_wheel_mixer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .stick_valid (stick_valid),
        .stick_stall (stick_stall),
        .stick       (stick),
        .mix_valid   (mix_valid),
        .mix_stall   (mix_stall),
        .mix         (mix),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches all three channels, predicts and compares
    mjwm_mix_checker u_mix_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stick_valid (stick_valid),
        .stick_stall (stick_stall),
        .stick       (stick),
        .mix_valid   (mix_valid),
        .mix_stall   (mix_stall),
        .mix         (mix),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short idle runs, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // sample biased toward the band edges and the clamp point
    function automatic int pick_sample(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0, 1:    return $urandom_range(0, 4095);
            2:       return clamp_sample(lo - $urandom_range(0, 40));
            3:       return clamp_sample(hi + $urandom_range(0, 40));
            4:       return $urandom_range(hi, lo);
            5:       return clamp_sample(hi + $urandom_range(1400, 1600));
            6:       return clamp_sample(lo - $urandom_range(1400, 1600));
            default: return $urandom_range(0, 1) ? 0 : 4095;
        endcase
    endfunction

    // offer one stick request, return at the falling edge after it is taken;
    // valid stays high so back-to-back requests need no extra drive
    task automatic send_stick(input int x, input int y, input int r);
        int gap;
        gap = tx_calm ? 0 : ($urandom_range(0, 1) ? 0 : idle_len());
        if (gap > 0)
        begin
            stick_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stick_valid <= 1'b1;
        stick <= '{stick_x: 12'(x), stick_y: 12'(y), stick_rotate: 12'(r)};
        do
            @(posedge clk);
        while (!(stick_valid && !stick_stall));
        @(negedge clk);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        stick_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // both band edges written back to back while the mixer is empty
    task automatic set_band(input int lo, input int hi);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEAD_BAND_LOW;
        cfg_data <= 12'(lo);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_DEAD_BAND_HIGH;
        cfg_data <= 12'(hi);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_band(input int lo, input int hi, input int count);
        set_band(lo, hi);
        repeat (count)
            send_stick(pick_sample(lo, hi), pick_sample(lo, hi), pick_sample(lo, hi));
    endtask

    // mix receiver: random stall runs, calm stretches, and one long hold-off
    initial
    begin : mix_receiver
        int   seg;
        logic hold;
        seg = 0;
        hold = 1'b0;
        mix_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // long stall so the pipeline fills and pushes back on stick
                mix_stall <= 1'b1;
                repeat (64) @(negedge clk);
                mix_stall <= 1'b0;
                hold_off_req = 1'b0;
                hold = 1'b0;
                seg = $urandom_range(4, 12);
            end
            else if (rx_calm)
            begin
                mix_stall <= 1'b0;
            end
            else
            begin
                if (seg == 0)
                begin
                    hold = ($urandom_range(0, 2) == 0);
                    seg = hold ? idle_len() : $urandom_range(1, 16);
                end
                mix_stall <= hold;
                seg--;
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #20000000;
        $display("FAIL mecanum_joystick_wheel_mixer_top");
        $finish;
    end

    initial
    begin : stimulus
        int lo;
        int hi;
        // every input known from time zero
        stick_valid = 1'b0;
        stick = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEAD_BAND_LOW;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed requests against the reset band
        foreach (DIRECTED[i])
            send_stick(DIRECTED[i][0], DIRECTED[i][1], DIRECTED[i][2]);

        run_band(DEAD_BAND_LOW_RST, DEAD_BAND_HIGH_RST, 200);

        // no idling on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_band(0, 4095, 120);
        run_band(4095, 0, 150);
        rx_calm = 1'b0;

        // receiver holds off while the sender keeps offering back to back
        set_band(2000, 2100);
        hold_off_req = 1'b1;
        repeat (100)
            send_stick(pick_sample(2000, 2100), pick_sample(2000, 2100),
                       pick_sample(2000, 2100));
        tx_calm = 1'b0;

        run_band(2048, 2048, 150);
        run_band(0, 0, 100);
        run_band(4095, 4095, 100);

        // random band settings, the last one with crossed edges
        repeat (2)
        begin
            lo = $urandom_range(200, 2000);
            hi = $urandom_range(lo, 3800);
            run_band(lo, hi, 150);
        end
        hi = $urandom_range(500, 2000);
        lo = $urandom_range(hi + 1, 3500);
        run_band(lo, hi, 150);

        run_band(DEAD_BAND_LOW_RST, DEAD_BAND_HIGH_RST, 150);

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS mecanum_joystick_wheel_mixer_top");
        else
            $display("FAIL mecanum_joystick_wheel_mixer_top");
        $finish;
    end

endmodule
